/* design/splat_alpha_compositor_top_macros.svh */
// Assertion macros for the splat alpha compositor checker.
// Plain text macros, no dependencies.
`ifndef SPLAT_ALPHA_COMPOSITOR_TOP_MACROS_SVH
`define SPLAT_ALPHA_COMPOSITOR_TOP_MACROS_SVH

// Same-cycle implication, off during reset
`define SAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define SAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, always on
`define SAC_ASSERT_NEXT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sac_pkg.sv */
// Shared types and constants of the splat alpha compositor.
// No dependencies; used by the RTL and the checker.
`default_nettype none

package sac_pkg;

    // Port field widths
    localparam int OP_W       = 2;
    localparam int ALPHA_W    = 8;
    localparam int DC_W       = 16;
    localparam int CUTOFF_W   = 17;
    localparam int PIXEL_W    = 32;
    localparam int BYTE_W     = 8;

    // Default fixed-point formats
    localparam int OPACITY_FRAC_BITS_DEF = 16;
    localparam int COEFF_FRAC_BITS_DEF   = 12;

    // Cutoff register value after reset
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 17'd7;

    // Degree-0 SH constant 0.28209479 in Q0.24
    localparam int SH_C0_Q24  = 4732765;
    localparam int SH_C0_FRAC = 24;
    localparam int SH_C0_W    = 23;

    // Alpha byte of every output pixel
    localparam logic [BYTE_W-1:0] PIXEL_ALPHA = 8'hFF;

    // Input operation codes
    typedef enum logic [OP_W-1:0] {
        OP_HIT     = 2'd0,
        OP_HIT_END = 2'd1,
        OP_EMPTY   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

endpackage

`default_nettype wire

/* design/sac_mul.sv */
// Shared signed multiplier of the compositor, one registered product per cycle.
// No package dependencies.
`default_nettype none

module sac_mul #(
    parameter int A_W = 18,
    parameter int B_W = 24
) (
    input  wire logic                      i_clk,
    input  wire logic signed [A_W-1:0]     i_a,
    input  wire logic signed [B_W-1:0]     i_b,
    output logic signed [A_W+B_W-1:0]      o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    // Product register, no reset (payload only)
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* design/splat_alpha_compositor_top.sv */
// Splat alpha compositor: front-to-back blending of the hits along one ray into an
// RGBA8888 pixel, with degree-0 SH colour per hit. Uses sac_pkg and sac_mul. All
// arithmetic runs through one registered multiplier under a step sequencer: a hit
// (op 0 or 1) occupies its accept cycle and then nine sequencer steps with the input
// stalled (two transmittance products, three colour products, three weighted
// products and the last accumulate).
// An op-1 hit that ends with T at or below the cutoff goes on to the three byte
// scalings and the output load. The finished pixel sits in an output register, so
// the next hit is accepted while it waits; only a second ray end waits for it to
// drain. Op code 3 is dropped in its accept cycle. The cutoff register may be
// written at any time the block is idle and takes effect on the next packet end.
`default_nettype none

module splat_alpha_compositor_top #(
    parameter int OPACITY_FRAC_BITS = sac_pkg::OPACITY_FRAC_BITS_DEF,
    parameter int COEFF_FRAC_BITS   = sac_pkg::COEFF_FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [sac_pkg::CUTOFF_W-1:0]     i_cfg_wr_data,
    // hit channel
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [sac_pkg::OP_W-1:0]         i_op,
    input  wire logic [sac_pkg::ALPHA_W-1:0]      i_alpha,
    input  wire logic signed [sac_pkg::DC_W-1:0]  i_dc_red,
    input  wire logic signed [sac_pkg::DC_W-1:0]  i_dc_green,
    input  wire logic signed [sac_pkg::DC_W-1:0]  i_dc_blue,
    // pixel channel
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [sac_pkg::PIXEL_W-1:0]           o_pixel,
    output logic                                  o_stopped_by_opacity
);

    // Formats
    localparam int F     = OPACITY_FRAC_BITS;
    localparam int TW    = F + 1;                         // Q1.F transmittance, weight
    localparam int CW    = F + sac_pkg::DC_W - COEFF_FRAC_BITS; // colour
    localparam int ACCW  = F + 4;                         // Q4.F accumulator
    localparam int SHIFT = COEFF_FRAC_BITS + sac_pkg::SH_C0_FRAC - F;
    localparam int AX    = 2 * sac_pkg::ALPHA_W + F + 1;  // alpha expansion
    localparam int MA    = (TW + 1 > sac_pkg::DC_W) ? TW + 1 : sac_pkg::DC_W;
    localparam int MB0   = (TW + 1 > sac_pkg::SH_C0_W + 1) ? TW + 1 : sac_pkg::SH_C0_W + 1;
    localparam int MB    = (MB0 > CW + 1) ? MB0 : CW + 1;
    localparam int PW    = MA + MB;
    localparam int SUMW  = ((ACCW > CW) ? ACCW : CW) + 1;
    localparam int CMPW  = (TW > sac_pkg::CUTOFF_W) ? TW : sac_pkg::CUTOFF_W;

    localparam logic [TW-1:0]         T_ONE   = TW'(1) << F;
    localparam logic [ACCW-1:0]       ACC_MAX = '1;
    localparam logic signed [PW-1:0]  F_RND   = PW'(1) << (F - 1);
    localparam logic signed [PW-1:0]  C_RND   = PW'(1) << (SHIFT - 1);

    // Sequencer steps during a hit
    localparam logic [3:0] HS_TA    = 4'd0;  // T*a
    localparam logic [3:0] HS_TNA   = 4'd1;  // T*(1-a), take w
    localparam logic [3:0] HS_COL0  = 4'd2;  // dc*C0 red, take new T
    localparam logic [3:0] HS_COL2  = 4'd4;
    localparam logic [3:0] HS_WC0   = 4'd5;  // w*c red
    localparam logic [3:0] HS_WC2   = 4'd7;
    localparam logic [3:0] HS_LAST  = 4'd8;  // last accumulate
    // Steps during pixel output
    localparam logic [3:0] PS_MUL2  = 4'd2;  // last byte scaling issued
    localparam logic [3:0] PS_LOAD  = 4'd4;  // load output register

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HIT,
        ST_PIX
    } t_state;

    t_state                      r_state;
    logic [3:0]                  r_step;
    logic                        r_close;
    logic                        r_stopped;
    logic [sac_pkg::CUTOFF_W-1:0] r_cutoff;
    logic [F-1:0]                r_a;
    logic signed [sac_pkg::DC_W-1:0] r_dc [3];
    logic [TW-1:0]               r_w;
    logic [TW-1:0]               r_t;
    logic [CW-1:0]               r_col [3];
    logic [ACCW-1:0]             r_acc [3];
    logic [sac_pkg::BYTE_W-1:0]  r_byte [3];
    logic                        r_out_valid;
    logic [sac_pkg::PIXEL_W-1:0] r_pixel;
    logic                        r_out_stopped;

    logic signed [MA-1:0]        mul_a;
    logic signed [MB-1:0]        mul_b;
    logic signed [PW-1:0]        prod;

    // Alpha byte to Q0.F: alpha*257 rescaled with rounding
    logic [AX-1:0]               a_ext;
    logic [F-1:0]                a_in;
    assign a_ext = (AX'({i_alpha, i_alpha}) << F) + AX'(32768);
    assign a_in  = a_ext[F+15:16];

    // Channel selects for the step in progress
    logic [3:0] dc_diff, colw_diff, colr_diff, acc_diff, byte_diff;
    logic [1:0] dc_rd, col_wr, col_rd, acc_rd, byte_wr;
    assign dc_diff   = r_step - HS_COL0;
    assign colw_diff = r_step - (HS_COL0 + 4'd1);
    assign colr_diff = r_step - HS_WC0;
    assign acc_diff  = (r_state == ST_HIT) ? r_step - (HS_WC0 + 4'd1) : r_step;
    assign byte_diff = r_step - 4'd1;
    assign dc_rd     = dc_diff[1:0];
    assign col_wr    = colw_diff[1:0];
    assign col_rd    = colr_diff[1:0];
    assign acc_rd    = acc_diff[1:0];
    assign byte_wr   = byte_diff[1:0];

    // Rounded results of the last product
    logic signed [PW-1:0] prod_rnd;
    logic signed [PW-1:0] col_sh;
    logic signed [PW-1:0] col_v;
    logic [CW-1:0]        col_val;
    logic [SUMW-1:0]      acc_sum;
    logic [ACCW-1:0]      acc_sat;
    logic [ACCW-1:0]      acc_cur;
    logic [TW-1:0]        acc_clip;
    logic [TW-1:0]        one_minus_a;
    logic                 t_le_cut;
    logic                 out_free;
    logic                 out_load;

    assign prod_rnd    = (prod + F_RND) >>> F;
    assign col_sh      = (prod + C_RND) >>> SHIFT;
    assign col_v       = col_sh + F_RND;
    assign col_val     = col_v[PW-1] ? '0 : col_v[CW-1:0];
    assign acc_cur     = r_acc[acc_rd];
    assign acc_sum     = SUMW'(acc_cur) + SUMW'(prod_rnd[CW-1:0]);
    assign acc_sat     = (acc_sum > SUMW'(ACC_MAX)) ? ACC_MAX : acc_sum[ACCW-1:0];
    assign acc_clip    = (acc_cur > ACCW'(T_ONE)) ? T_ONE : acc_cur[TW-1:0];
    assign one_minus_a = T_ONE - TW'(r_a);
    assign t_le_cut    = CMPW'(r_t) <= CMPW'(r_cutoff);
    assign out_free    = !r_out_valid || !i_stall;
    assign out_load    = (r_state == ST_PIX) && (r_step == PS_LOAD) && out_free;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_HIT: begin
                if (r_step == HS_TA) begin
                    mul_a = MA'(signed'({1'b0, r_t}));
                    mul_b = MB'(signed'({1'b0, r_a}));
                end else if (r_step == HS_TNA) begin
                    mul_a = MA'(signed'({1'b0, r_t}));
                    mul_b = MB'(signed'({1'b0, one_minus_a}));
                end else if (r_step >= HS_COL0 && r_step <= HS_COL2) begin
                    mul_a = MA'(r_dc[dc_rd]);
                    mul_b = MB'(sac_pkg::SH_C0_Q24);
                end else if (r_step >= HS_WC0 && r_step <= HS_WC2) begin
                    mul_a = MA'(signed'({1'b0, r_w}));
                    mul_b = MB'(signed'({1'b0, r_col[col_rd]}));
                end
            end
            ST_PIX: begin
                if (r_step <= PS_MUL2) begin
                    mul_a = MA'(signed'({1'b0, acc_clip}));
                    mul_b = MB'(255);
                end
            end
            default: begin
            end
        endcase
    end

    sac_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_sac_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Sequencer, ray state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_close     <= 1'b0;
            r_stopped   <= 1'b0;
            r_cutoff    <= sac_pkg::CUTOFF_RESET;
            r_t         <= T_ONE;
            r_acc[0]    <= '0;
            r_acc[1]    <= '0;
            r_acc[2]    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cutoff <= i_cfg_wr_data;
            end
            if (r_out_valid && !i_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                    if (i_valid) begin
                        r_a      <= a_in;
                        r_dc[0]  <= i_dc_red;
                        r_dc[1]  <= i_dc_green;
                        r_dc[2]  <= i_dc_blue;
                        case (sac_pkg::t_op'(i_op))
                            sac_pkg::OP_HIT, sac_pkg::OP_HIT_END: begin
                                r_state <= ST_HIT;
                                r_close <= (sac_pkg::t_op'(i_op) == sac_pkg::OP_HIT_END);
                            end
                            sac_pkg::OP_EMPTY: begin
                                r_state   <= ST_PIX;
                                r_stopped <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                ST_HIT: begin
                    if (r_step == HS_TNA) begin
                        r_w <= prod_rnd[TW-1:0];
                    end
                    if (r_step == HS_COL0) begin
                        r_t <= prod_rnd[TW-1:0];
                    end
                    if (r_step > HS_COL0 && r_step <= HS_WC0) begin
                        r_col[col_wr] <= col_val;
                    end
                    if (r_step > HS_WC0) begin
                        r_acc[acc_rd] <= acc_sat;
                    end
                    if (r_step == HS_LAST) begin
                        r_step <= '0;
                        if (r_close && t_le_cut) begin
                            r_state   <= ST_PIX;
                            r_stopped <= 1'b1;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end

                ST_PIX: begin
                    if (r_step != PS_LOAD) begin
                        r_step <= r_step + 4'd1;
                    end
                    if (r_step != '0 && r_step != PS_LOAD) begin
                        r_byte[byte_wr] <= prod_rnd[sac_pkg::BYTE_W-1:0];
                    end
                    // hand the pixel over and start a fresh ray
                    if (out_load) begin
                        r_out_valid   <= 1'b1;
                        r_pixel       <= {sac_pkg::PIXEL_ALPHA, r_byte[2], r_byte[1],
                                          r_byte[0]};
                        r_out_stopped <= r_stopped;
                        r_t           <= T_ONE;
                        r_acc[0]      <= '0;
                        r_acc[1]      <= '0;
                        r_acc[2]      <= '0;
                        r_step        <= '0;
                        r_state       <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall              = (r_state != ST_IDLE);
    assign o_valid              = r_out_valid;
    assign o_pixel              = r_pixel;
    assign o_stopped_by_opacity = r_out_stopped;

endmodule

`default_nettype wire

/* design/sac_checker.sv */
// Port-level checker for splat_alpha_compositor_top, bound to the top level.
// Uses sac_pkg and splat_alpha_compositor_top_macros.svh.
`default_nettype none

`include "splat_alpha_compositor_top_macros.svh"

module sac_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_valid,
    input wire logic                             o_stall,
    input wire logic [sac_pkg::OP_W-1:0]         i_op,
    input wire logic                             o_valid,
    input wire logic                             i_stall,
    input wire logic [sac_pkg::PIXEL_W-1:0]      o_pixel,
    input wire logic                             o_stopped_by_opacity
);

    // A stalled pixel transfer holds its payload
    `SAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pixel) && $stable(o_stopped_by_opacity), "stalled pixel changed")

    // Every pixel carries an opaque alpha byte
    `SAC_ASSERT_SAME(a_pixel_alpha, i_clk, i_rst_n, o_valid, o_pixel[31:24] == sac_pkg::PIXEL_ALPHA, "pixel alpha byte is not 0xff")

    // A hit or empty-packet transfer keeps the sequencer busy next cycle
    `SAC_ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, i_valid && !o_stall && i_op != sac_pkg::OP_NONE, o_stall, "block ready right after taking an item")

    // Reset leaves the block idle with no pixel pending
    `SAC_ASSERT_NEXT_ALL(a_reset_idle, i_clk, !i_rst_n, !o_valid && !o_stall, "block not idle after reset")

endmodule

bind splat_alpha_compositor_top sac_checker u_sac_checker (.*);

`default_nettype wire
